// ===== rtl/rse_pkg.sv =====
// Shared types, codes and the xorshift step for the randomized set engine.
// Used by rse_ctrl, rse_dp and randomized_set_engine; depends on nothing.
package rse_pkg;

  localparam int GenW     = 32;
  localparam int DataW    = 32;
  localparam int DivCntW  = $clog2(GenW + 1);
  localparam int ApbAddrW = 2;
  localparam int ApbDataW = 32;

  localparam logic [GenW-1:0]     SEED_RESET = 32'd1;
  localparam logic [ApbAddrW-1:0] REG_SEED   = 2'd0;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LAST,
    RD_DRAW
  } rd_sel_t;

  typedef struct packed {
    logic    in_take;
    logic    scan_run;
    logic    ins_write;
    logic    rm_write;
    logic    gen_step;
    logic    div_start;
    logic    div_run;
    logic    set_ok;
    logic    set_full;
    logic    set_drawn;
    logic    out_load;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       scan_done;
    logic       found;
    logic       count_zero;
    logic       count_full;
    logic       div_done;
    logic       out_free;
  } stat_t;

  function automatic logic [GenW-1:0] xorshift32(input logic [GenW-1:0] s);
    logic [GenW-1:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ===== rtl/rse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rse_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rse_ctrl.sv =====
// Operation sequencer for the randomized set engine.
// Drives rse_pkg::cmd_t to the datapath and reads rse_pkg::stat_t back.
module rse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rse_pkg::stat_t stat,
  output rse_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DISPATCH,
    SCAN,
    RM_RD,
    RM_WR,
    GEN,
    DIV,
    DRAW_RD,
    DRAW_CAP,
    DONE
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = rse_pkg::RD_SCAN;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_next  = DISPATCH;
        end
      end
      DISPATCH: begin
        case (stat.kind)
          rse_pkg::KIND_INSERT, rse_pkg::KIND_REMOVE: state_next = SCAN;
          rse_pkg::KIND_DRAW: begin
            if (stat.count_zero) begin
              state_next = DONE;
            end else begin
              cmd.gen_step = 1'b1;
              state_next   = GEN;
            end
          end
          default: state_next = DONE;
        endcase
      end
      SCAN: begin
        cmd.scan_run = !stat.scan_done;
        if (stat.scan_done) begin
          if (stat.kind == rse_pkg::KIND_REMOVE) begin
            state_next = stat.found ? RM_RD : DONE;
          end else begin
            if (!stat.found) begin
              if (stat.count_full) begin
                cmd.set_full = 1'b1;
              end else begin
                cmd.ins_write = 1'b1;
                cmd.set_ok    = 1'b1;
              end
            end
            state_next = DONE;
          end
        end
      end
      RM_RD: begin
        cmd.rd_sel = rse_pkg::RD_LAST;
        state_next = RM_WR;
      end
      RM_WR: begin
        cmd.rm_write = 1'b1;
        cmd.set_ok   = 1'b1;
        state_next   = DONE;
      end
      GEN: begin
        cmd.div_start = 1'b1;
        state_next    = DIV;
      end
      DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_done) begin
          state_next = DRAW_RD;
        end
      end
      DRAW_RD: begin
        cmd.rd_sel = rse_pkg::RD_DRAW;
        state_next = DRAW_CAP;
      end
      DRAW_CAP: begin
        cmd.set_drawn = 1'b1;
        cmd.set_ok    = 1'b1;
        state_next    = DONE;
      end
      DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/rse_dp.sv =====
// Datapath: element store, live count, membership scan, xorshift generator,
// bit-serial modulo unit and result register. Uses rse_pkg and rse_ram.
module rse_dp #(
  parameter int SET_DEPTH = 64,
  localparam int IdxW = $clog2(SET_DEPTH),
  localparam int CntW = $clog2(SET_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rse_pkg::cmd_t             cmd,
  output rse_pkg::stat_t            stat,
  input  logic                      cfg_we,
  input  logic [rse_pkg::GenW-1:0]  cfg_data,
  output logic [rse_pkg::GenW-1:0]  seed,
  input  logic [1:0]                kind,
  input  logic signed [rse_pkg::DataW-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic                      store_full,
  output logic signed [rse_pkg::DataW-1:0] drawn_value,
  output logic [CntW-1:0]           element_count
);

  logic [1:0]                kind_r;
  logic [rse_pkg::DataW-1:0] value_r;
  logic [CntW-1:0]           count;
  logic [CntW-1:0]           count_m1;
  logic                      count_full;
  logic                      count_zero;

  logic [CntW-1:0]           scan_idx;
  logic                      cmp_vld;
  logic [IdxW-1:0]           cmp_idx;
  logic                      found;
  logic [IdxW-1:0]           slot;
  logic                      hit;
  logic                      issue;
  logic                      scan_done;

  logic [rse_pkg::GenW-1:0]    gen;
  logic [rse_pkg::GenW-1:0]    quot;
  logic [CntW-1:0]             rem;
  logic [rse_pkg::DivCntW-1:0] div_cnt;
  logic                        div_done;
  logic [CntW:0]               div_trial;
  logic                        div_ge;
  logic [CntW:0]               div_diff;

  logic                      res_ok;
  logic                      res_full;
  logic [rse_pkg::DataW-1:0] res_drawn;
  logic                      out_free;

  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  logic [rse_pkg::DataW-1:0] ram_wdata;
  logic [IdxW-1:0]           ram_raddr;
  logic [rse_pkg::DataW-1:0] ram_rdata;

  assign count_m1   = count - CntW'(1);
  assign count_full = (count == CntW'(SET_DEPTH));
  assign count_zero = (count == '0);

  assign hit       = cmp_vld && (ram_rdata == value_r);
  assign issue     = cmd.scan_run && (scan_idx < count) && !found && !hit;
  assign scan_done = found || (!cmp_vld && (scan_idx >= count));

  assign div_done  = (div_cnt == rse_pkg::DivCntW'(rse_pkg::GenW));
  assign div_trial = {rem, quot[rse_pkg::GenW-1]};
  assign div_ge    = (div_trial >= {1'b0, count});
  assign div_diff  = div_trial - {1'b0, count};

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.kind       = kind_r;
    stat.scan_done  = scan_done;
    stat.found      = found;
    stat.count_zero = count_zero;
    stat.count_full = count_full;
    stat.div_done   = div_done;
    stat.out_free   = out_free;
  end

  always_comb begin
    case (cmd.rd_sel)
      rse_pkg::RD_LAST: ram_raddr = count_m1[IdxW-1:0];
      rse_pkg::RD_DRAW: ram_raddr = rem[IdxW-1:0];
      default:          ram_raddr = scan_idx[IdxW-1:0];
    endcase
  end

  assign ram_we    = cmd.ins_write || cmd.rm_write;
  assign ram_waddr = cmd.rm_write ? slot : count[IdxW-1:0];
  assign ram_wdata = cmd.rm_write ? ram_rdata : value_r;

  rse_ram #(
    .Width(rse_pkg::DataW),
    .Depth(SET_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      kind_r  <= kind;
      value_r <= value;
    end
    if (issue) begin
      cmp_idx <= scan_idx[IdxW-1:0];
    end
    if (hit) begin
      slot <= cmp_idx;
    end
    if (cmd.div_start) begin
      quot <= gen;
      rem  <= '0;
    end else if (cmd.div_run && !div_done) begin
      quot <= quot << 1;
      rem  <= div_ge ? div_diff[CntW-1:0] : div_trial[CntW-1:0];
    end
    if (cmd.in_take) begin
      res_drawn <= '0;
    end else if (cmd.set_drawn) begin
      res_drawn <= ram_rdata;
    end
    if (cmd.out_load) begin
      ok            <= res_ok;
      store_full    <= res_full;
      drawn_value   <= res_drawn;
      element_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      cmp_vld   <= 1'b0;
      found     <= 1'b0;
      seed      <= rse_pkg::SEED_RESET;
      gen       <= rse_pkg::SEED_RESET;
      div_cnt   <= '0;
      res_ok    <= 1'b0;
      res_full  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.ins_write) begin
        count <= count + CntW'(1);
      end else if (cmd.rm_write) begin
        count <= count_m1;
      end

      if (cmd.in_take) begin
        scan_idx <= '0;
        cmp_vld  <= 1'b0;
        found    <= 1'b0;
      end else begin
        cmp_vld <= issue;
        if (issue) begin
          scan_idx <= scan_idx + CntW'(1);
        end
        if (hit) begin
          found <= 1'b1;
        end
      end

      if (cfg_we) begin
        seed <= cfg_data;
        gen  <= cfg_data;
      end else if (cmd.gen_step) begin
        gen <= rse_pkg::xorshift32(gen);
      end

      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_run && !div_done) begin
        div_cnt <= div_cnt + rse_pkg::DivCntW'(1);
      end

      if (cmd.in_take) begin
        res_ok   <= 1'b0;
        res_full <= 1'b0;
      end else begin
        if (cmd.set_ok) begin
          res_ok <= 1'b1;
        end
        if (cmd.set_full) begin
          res_full <= 1'b1;
        end
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(SET_DEPTH))
    else $error("live count above store depth");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> !count_full && !found)
    else $error("insert written into full store or over a present value");

  a_remove_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.rm_write |-> found && !count_zero)
    else $error("remove without a matching live entry");

  a_draw_index: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_sel == rse_pkg::RD_DRAW |-> rem < count)
    else $error("draw index not below live count");

endmodule

// ===== rtl/randomized_set_engine.sv =====
// Randomized set engine top: one word in, one result word out per operation.
// Insert/remove: the result waits on the membership scan, which checks one entry per cycle.
// Draw: the result waits on the 32-step bit-serial modulo unit; an empty set skips it.
// One operation in flight; next word taken in the cycle after the result loads, even while
// it waits. Reset: synchronous; count cleared, generator loaded with 1, store not cleared.
module randomized_set_engine #(
  parameter int SET_DEPTH = 64,
  localparam int CntW = $clog2(SET_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rse_pkg::ApbAddrW-1:0]        paddr,
  input  logic [rse_pkg::ApbDataW-1:0]        pwdata,
  output logic [rse_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic signed [rse_pkg::DataW-1:0]    value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ok,
  output logic                                store_full,
  output logic signed [rse_pkg::DataW-1:0]    drawn_value,
  output logic [CntW-1:0]                     element_count
);

  rse_pkg::cmd_t            cmd;
  rse_pkg::stat_t           stat;
  logic                     cfg_we;
  logic                     seed_sel;
  logic [rse_pkg::GenW-1:0] seed;

  assign pready   = 1'b1;
  assign seed_sel = (paddr == rse_pkg::REG_SEED);
  assign cfg_we   = psel && penable && pwrite && seed_sel;
  assign prdata   = seed_sel ? seed : '0;

  rse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  rse_dp #(
    .SET_DEPTH(SET_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_data     (pwdata),
    .seed         (seed),
    .kind         (kind),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .store_full   (store_full),
    .drawn_value  (drawn_value),
    .element_count(element_count)
  );

endmodule

// ===== tb/sv/tb_randomized_set_engine.sv =====
// Self-checking testbench for randomized_set_engine: insert, remove and draw words
// are checked against an in-bench set model with its own xorshift generator.
// Depends on rse_pkg and the randomized_set_engine RTL only.
module tb_randomized_set_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_DEPTH  = 64;
  localparam int CNT_W      = $clog2(SET_DEPTH + 1);
  localparam int POOL_N     = 96;
  localparam int HOLD_LEN   = 300;
  localparam int STUCK_MAX  = 4000;
  localparam int SETTLE_CYC = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic                      ok;
    logic                      full;
    logic [rse_pkg::DataW-1:0] drawn;
    logic [CNT_W-1:0]          count;
  } set_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [rse_pkg::ApbAddrW-1:0]     paddr = '0;
  logic [rse_pkg::ApbDataW-1:0]     pwdata = '0;
  logic [rse_pkg::ApbDataW-1:0]     prdata;
  logic                             pready;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [1:0]                       kind = rse_pkg::KIND_INSERT;
  logic signed [rse_pkg::DataW-1:0] value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             ok;
  logic                             store_full;
  logic signed [rse_pkg::DataW-1:0] drawn_value;
  logic [CNT_W-1:0]                 element_count;

  logic [rse_pkg::DataW-1:0] set_slots [SET_DEPTH];
  int                        set_count = 0;
  logic [rse_pkg::GenW-1:0]  gen_state = rse_pkg::SEED_RESET;
  logic [rse_pkg::DataW-1:0] value_pool [POOL_N];
  set_result_t               expected_results [$];

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int errors = 0;
  int n_words = 0;
  int n_draws = 0;
  int n_refused = 0;
  int stuck_cycles = 0;

  randomized_set_engine #(.SET_DEPTH(SET_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok), .store_full(store_full),
    .drawn_value(drawn_value), .element_count(element_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic set_result_t predict_op(input logic [1:0] k,
                                             input logic [rse_pkg::DataW-1:0] v);
    set_result_t r;
    int slot;
    logic [rse_pkg::GenW-1:0] x;
    r = '{ok: 1'b0, full: 1'b0, drawn: '0, count: '0};
    slot = -1;
    for (int i = 0; i < set_count; i++)
      if (slot < 0 && set_slots[i] == v) slot = i;
    case (k)
      rse_pkg::KIND_INSERT: begin
        if (slot < 0) begin
          if (set_count >= SET_DEPTH) begin
            r.full = 1'b1;
          end else begin
            set_slots[set_count] = v;
            set_count++;
            r.ok = 1'b1;
          end
        end
      end
      rse_pkg::KIND_REMOVE: begin
        if (slot >= 0) begin
          set_slots[slot] = set_slots[set_count-1];
          set_count--;
          r.ok = 1'b1;
        end
      end
      rse_pkg::KIND_DRAW: begin
        if (set_count != 0) begin
          x = gen_state;
          x = x ^ (x << 13);
          x = x ^ (x >> 17);
          x = x ^ (x << 5);
          gen_state = x;
          r.drawn = set_slots[x % set_count];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = set_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [rse_pkg::DataW-1:0] got,
                                 input logic [rse_pkg::DataW-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_word(input logic [1:0] k, input logic [rse_pkg::DataW-1:0] v);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    expected_results.insert(expected_results.size(), predict_op(k, v));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // write the seed, then read it back
  task automatic load_seed(input logic [rse_pkg::GenW-1:0] s);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rse_pkg::REG_SEED;
    pwdata  <= s;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gen_state = s;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== s) report_mismatch("seed readback", prdata, s);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_op(input int ins_pct, input int rm_pct, input int draw_pct);
    int pick;
    logic [1:0] k;
    logic [rse_pkg::DataW-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) k = rse_pkg::KIND_INSERT;
    else if (pick < ins_pct + rm_pct) k = rse_pkg::KIND_REMOVE;
    else if (pick < ins_pct + rm_pct + draw_pct) k = rse_pkg::KIND_DRAW;
    else k = KIND_UNUSED;
    v = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, POOL_N-1)] : $urandom();
    send_word(k, v);
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", drawn_value, '0);
      end else begin
        want = expected_results.pop_front();
        n_words++;
        if (ok !== want.ok)
          report_mismatch("ok", rse_pkg::DataW'(ok), rse_pkg::DataW'(want.ok));
        if (store_full !== want.full)
          report_mismatch("store_full", rse_pkg::DataW'(store_full),
                          rse_pkg::DataW'(want.full));
        if (drawn_value !== want.drawn) report_mismatch("drawn_value", drawn_value, want.drawn);
        if (element_count !== want.count)
          report_mismatch("element_count", rse_pkg::DataW'(element_count),
                          rse_pkg::DataW'(want.count));
        if (want.full) n_refused++;
        if (want.ok && want.drawn != 0) n_draws++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("%0t no word moved for %0d cycles", $realtime, stuck_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_reset_state();
    send_word(rse_pkg::KIND_DRAW, 32'h0000_0000);
    send_word(KIND_UNUSED, 32'h0000_0000);
    send_word(rse_pkg::KIND_REMOVE, 32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_extremes();
    send_word(rse_pkg::KIND_INSERT, 32'h8000_0000);
    send_word(rse_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    send_word(rse_pkg::KIND_INSERT, 32'h0000_0000);
    send_word(rse_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_word(rse_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    repeat (3) send_word(rse_pkg::KIND_DRAW, 32'h0000_0000);
    send_word(rse_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
    send_word(rse_pkg::KIND_REMOVE, 32'h1234_5678);
    send_word(KIND_UNUSED, 32'hFFFF_FFFF);
    send_word(rse_pkg::KIND_DRAW, 32'hFFFF_FFFF);
    send_word(rse_pkg::KIND_REMOVE, 32'h8000_0000);
    send_word(rse_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
    send_word(rse_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(rse_pkg::KIND_DRAW, 32'h0000_0000);
    send_word(rse_pkg::KIND_INSERT, 32'h0000_0001);
    wait_idle();
  endtask

  task automatic test_fill_to_full();
    load_seed(32'hFFFF_FFFF);
    repeat (500) random_op(70, 10, 18);
    wait_idle();
  endtask

  task automatic test_input_backpressure();
    hold_req = 1'b1;
    repeat (40) random_op(30, 30, 35);
    wait_idle();
  endtask

  task automatic test_drain_to_empty();
    load_seed($urandom() | 32'h1);
    repeat (400) random_op(20, 60, 18);
    wait_idle();
  endtask

  task automatic test_zero_seed();
    load_seed(32'h0000_0000);
    repeat (150) random_op(40, 25, 33);
    wait_idle();
  endtask

  task automatic test_mixed_traffic();
    load_seed($urandom() | 32'h1);
    repeat (600) random_op(40, 25, 30);
    wait_idle();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    load_seed(32'h8000_0000);
    repeat (200) random_op(40, 25, 30);
    wait_idle();
  endtask

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h8000_0001;
    for (int i = 6; i < POOL_N; i++) value_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_extremes();
    test_fill_to_full();
    test_input_backpressure();
    test_drain_to_empty();
    test_zero_seed();
    test_mixed_traffic();
    test_steady_stream();
    if (expected_results.size() != 0)
      report_mismatch("results left over", expected_results.size(), '0);
    $display("Checked %0d result words; %0d draws returned nonzero, %0d inserts refused.",
             n_words, n_draws, n_refused);
    $display("Seeds: reset, all ones, zero and random; one long output hold-off filled the engine.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
